>>> sv/rtm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtm_pkg
// Shared types, register indexes and constants of the resolution table matcher.
// ----------------------------------------------------------------------------
package rtm_pkg;

    localparam int MAX_ENTRIES_DEF = 4;
    localparam int DIM_BITS_DEF    = 16;

    // Port widths fixed by the item format
    localparam int FIELD_W     = 16;
    localparam int INDEX_OUT_W = 2;
    localparam int OUTCOME_W   = 2;

    // Configuration port
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 3;
    localparam int COUNT_W       = 3;
    localparam int PCT_W         = 7;
    localparam int NUM_SIZE_REGS = 4;
    localparam int WIDTH_SHIFT   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_ENTRY_0   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MISMATCH_LIMIT = 3'd5;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;
    localparam logic [PCT_W-1:0]   PCT_RESET   = 7'd10;

    // 640x480, 720x480, 1280x720, 1920x1080
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET [NUM_SIZE_REGS] = '{
        32'h0280_01E0, 32'h02D0_01E0, 32'h0500_02D0, 32'h0780_0438
    };

    // Ratios are in units of 1/8192
    localparam int RATIO_SHIFT = 13;
    localparam int PERCENT     = 100;
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP       = (2 ** RECIP_SHIFT + PERCENT - 1) / PERCENT;
    localparam int RECIP_W     = 21;
    localparam int LIMIT_W     = 15;

    localparam logic [OUTCOME_W-1:0] OUTCOME_MATCHED  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_CLAMPED  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_NO_MATCH = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FETCH,
        ST_PREP,
        ST_TEST,
        ST_DIVIDE,
        ST_UPDATE,
        ST_FINISH,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic fetch;
        logic prep;
        logic div_load;
        logic div_step;
        logic update;
        logic idx_inc;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic go;
        logic last;
        logic div_done;
    } dp_status_t;

    // Mismatch limit plus one: floor(8192 * pct / 100) + 1, by reciprocal multiply
    function automatic logic [LIMIT_W-1:0] ratio_limit(input logic [PCT_W-1:0] pct);
        logic [PCT_W+RECIP_W-1:0] prod;
        prod = (PCT_W + RECIP_W)'(pct) * (PCT_W + RECIP_W)'(RECIP);
        return LIMIT_W'(prod >> (RECIP_SHIFT - RATIO_SHIFT)) + LIMIT_W'(1);
    endfunction

endpackage
`default_nettype wire

>>> sv/rtm_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtm_regs
// Configuration registers: entry count, size table and mismatch limit.
// ----------------------------------------------------------------------------
module rtm_regs #(
    parameter int MAX_ENTRIES = rtm_pkg::MAX_ENTRIES_DEF,
    parameter int DIM_BITS    = rtm_pkg::DIM_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 wr_en,
    input  wire logic [rtm_pkg::CFG_INDEX_W-1:0]      wr_index,
    input  wire logic [rtm_pkg::CFG_DATA_W-1:0]       wr_data,
    output logic      [rtm_pkg::COUNT_W-1:0]          count,
    output logic      [MAX_ENTRIES-1:0][2*DIM_BITS-1:0] entries,
    output logic      [rtm_pkg::PCT_W-1:0]            pct
);

    logic [rtm_pkg::COUNT_W-1:0] count_reg;
    logic [rtm_pkg::PCT_W-1:0]   pct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= rtm_pkg::COUNT_RESET;
            pct_reg   <= rtm_pkg::PCT_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == rtm_pkg::REG_ENTRY_COUNT)
            begin
                count_reg <= wr_data[rtm_pkg::COUNT_W-1:0];
            end
            if (wr_index == rtm_pkg::REG_MISMATCH_LIMIT)
            begin
                pct_reg <= wr_data[rtm_pkg::PCT_W-1:0];
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_ENTRIES; k++)
        begin : g_entry
            if (k < rtm_pkg::NUM_SIZE_REGS)
            begin : g_reg
                logic [2*DIM_BITS-1:0] entry_reg;

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        entry_reg <= {
                            rtm_pkg::SIZE_RESET[k][rtm_pkg::WIDTH_SHIFT +: DIM_BITS],
                            rtm_pkg::SIZE_RESET[k][0 +: DIM_BITS]};
                    end
                    else if (wr_en && (wr_index ==
                             rtm_pkg::CFG_INDEX_W'(rtm_pkg::REG_SIZE_ENTRY_0 + k)))
                    begin
                        entry_reg <= {wr_data[rtm_pkg::WIDTH_SHIFT +: DIM_BITS],
                                      wr_data[0 +: DIM_BITS]};
                    end
                end

                assign entries[k] = entry_reg;
            end
            else
            begin : g_zero
                // no register reaches this entry
                assign entries[k] = '0;
            end
        end
    endgenerate

    assign count = count_reg;
    assign pct   = pct_reg;

endmodule
`default_nettype wire

>>> sv/rtm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtm_ctrl
// Sequencer: walks the table one entry at a time and drives the datapath.
// ----------------------------------------------------------------------------
module rtm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire rtm_pkg::dp_status_t status,
    output rtm_pkg::dp_cmd_t         cmd,
    output logic                     busy,
    output logic                     done
);

    rtm_pkg::ctrl_state_t state_reg;
    rtm_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rtm_pkg::ST_SETUP;
                end
            end
            rtm_pkg::ST_SETUP:
            begin
                state_next = rtm_pkg::ST_FETCH;
            end
            rtm_pkg::ST_FETCH:
            begin
                state_next = status.skip ? rtm_pkg::ST_FINISH : rtm_pkg::ST_PREP;
            end
            rtm_pkg::ST_PREP:
            begin
                state_next = rtm_pkg::ST_TEST;
            end
            rtm_pkg::ST_TEST:
            begin
                if (status.go)
                begin
                    state_next = rtm_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = status.last ? rtm_pkg::ST_FINISH : rtm_pkg::ST_FETCH;
                end
            end
            rtm_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = rtm_pkg::ST_UPDATE;
                end
            end
            rtm_pkg::ST_UPDATE:
            begin
                state_next = status.last ? rtm_pkg::ST_FINISH : rtm_pkg::ST_FETCH;
            end
            rtm_pkg::ST_FINISH:
            begin
                state_next = rtm_pkg::ST_DONE;
            end
            rtm_pkg::ST_DONE:
            begin
                state_next = rtm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rtm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != rtm_pkg::ST_IDLE);
        done = (state_reg == rtm_pkg::ST_DONE);
        case (state_reg)
            rtm_pkg::ST_IDLE:
            begin
                cmd.capture = start;
            end
            rtm_pkg::ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            rtm_pkg::ST_FETCH:
            begin
                cmd.fetch = !status.skip;
            end
            rtm_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            rtm_pkg::ST_TEST:
            begin
                cmd.div_load = status.go;
                cmd.idx_inc  = !status.go && !status.last;
            end
            rtm_pkg::ST_DIVIDE:
            begin
                cmd.div_step = !status.div_done;
            end
            rtm_pkg::ST_UPDATE:
            begin
                cmd.update  = 1'b1;
                cmd.idx_inc = !status.last;
            end
            rtm_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/rtm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtm_datapath
// Request registers, products, mismatch test, bit-serial divider for the
// scale distance, best-entry tracking and result registers.
// ----------------------------------------------------------------------------
module rtm_datapath #(
    parameter int MAX_ENTRIES = rtm_pkg::MAX_ENTRIES_DEF,
    parameter int DIM_BITS    = rtm_pkg::DIM_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire rtm_pkg::dp_cmd_t                       cmd,
    output rtm_pkg::dp_status_t                         status,
    input  wire logic [rtm_pkg::FIELD_W-1:0]            req_width,
    input  wire logic [rtm_pkg::FIELD_W-1:0]            req_height,
    input  wire logic [rtm_pkg::COUNT_W-1:0]            count,
    input  wire logic [MAX_ENTRIES-1:0][2*DIM_BITS-1:0] entries,
    input  wire logic [rtm_pkg::PCT_W-1:0]              pct,
    output logic      [rtm_pkg::FIELD_W-1:0]            out_width,
    output logic      [rtm_pkg::FIELD_W-1:0]            out_height,
    output logic      [rtm_pkg::INDEX_OUT_W-1:0]        match_index,
    output logic      [rtm_pkg::OUTCOME_W-1:0]          outcome
);

    localparam int D      = DIM_BITS;
    localparam int P      = 2 * DIM_BITS;
    localparam int XW     = P + rtm_pkg::RATIO_SHIFT;
    localparam int NDD    = P + 1 + rtm_pkg::RATIO_SHIFT;
    localparam int BND_W  = P + rtm_pkg::LIMIT_W;
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW     = ($clog2(MAX_ENTRIES + 1) > rtm_pkg::COUNT_W) ?
                            $clog2(MAX_ENTRIES + 1) : rtm_pkg::COUNT_W;
    localparam int DCNT_W = $clog2(NDD + 1);

    logic [D-1:0]                 w1_reg, h1_reg;
    logic [D-1:0]                 lw_reg, lh_reg;
    logic [P-1:0]                 r_reg;
    logic [rtm_pkg::LIMIT_W-1:0]  lim_reg;
    logic [P-1:0]                 a_reg, b_reg;
    logic                         cand_reg;
    logic [XW-1:0]                diffx_reg;
    logic [BND_W-1:0]             bound_reg;
    logic [P:0]                   sum_reg;
    logic [NDD-1:0]               dvd_reg;
    logic [P-1:0]                 rem_reg;
    logic [NDD-1:0]               best_dist_reg;
    logic [IDX_W-1:0]             best_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [DCNT_W-1:0]            dcnt_reg;
    logic                         found_reg;
    logic [rtm_pkg::FIELD_W-1:0]  out_width_reg, out_height_reg;
    logic [rtm_pkg::INDEX_OUT_W-1:0] match_index_reg;
    logic [rtm_pkg::OUTCOME_W-1:0]   outcome_reg;

    logic [CW-1:0]    cnt_ext;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [P-1:0]     rd_entry;
    logic [D-1:0]     e_w, e_h;
    logic             clamp;
    logic [P-1:0]     abs_diff;
    logic [P:0]       trial;
    logic             trial_ge;
    logic [P:0]       trial_sub;
    logic             better;
    logic [IDX_W+1:0] best_ext;

    // effective entry count: zero counts as one, saturate at table depth
    always_comb
    begin
        cnt_ext = CW'(count);
        if (count == '0)
        begin
            last_idx = '0;
        end
        else if (cnt_ext > CW'(MAX_ENTRIES))
        begin
            last_idx = IDX_W'(MAX_ENTRIES - 1);
        end
        else
        begin
            last_idx = IDX_W'(cnt_ext - CW'(1));
        end
    end

    assign rd_idx   = cmd.setup ? last_idx : idx_reg;
    assign rd_entry = entries[rd_idx];
    assign e_w      = rd_entry[P-1:D];
    assign e_h      = rd_entry[D-1:0];

    assign clamp    = (w1_reg > lw_reg) || (h1_reg > lh_reg);
    assign abs_diff = (a_reg >= b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);

    // one restoring division step per cycle
    assign trial     = {rem_reg, dvd_reg[NDD-1]};
    assign trial_ge  = (trial >= {1'b0, r_reg});
    assign trial_sub = trial - {1'b0, r_reg};

    assign better = !found_reg || (dvd_reg < best_dist_reg);

    always_comb
    begin
        status.skip     = clamp || (w1_reg == '0) || (h1_reg == '0);
        // drop the entry when diff*8192 / (w1*h0) exceeds the limit
        status.go       = cand_reg && (BND_W'(diffx_reg) < bound_reg);
        status.last     = (idx_reg == last_idx);
        status.div_done = (dcnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.update && better)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.div_load)
            begin
                dcnt_reg <= DCNT_W'(NDD);
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            w1_reg <= req_width[D-1:0];
            h1_reg <= req_height[D-1:0];
        end
        if (cmd.setup)
        begin
            lw_reg  <= e_w;
            lh_reg  <= e_h;
            r_reg   <= P'(w1_reg) * P'(h1_reg);
            lim_reg <= rtm_pkg::ratio_limit(pct);
        end
        if (cmd.fetch)
        begin
            a_reg    <= P'(e_w) * P'(h1_reg);
            b_reg    <= P'(w1_reg) * P'(e_h);
            cand_reg <= (e_w >= w1_reg) && (e_h >= h1_reg);
        end
        if (cmd.prep)
        begin
            diffx_reg <= {abs_diff, {rtm_pkg::RATIO_SHIFT{1'b0}}};
            bound_reg <= BND_W'(lim_reg) * BND_W'(b_reg);
            sum_reg   <= {1'b0, a_reg} + {1'b0, b_reg};
        end
        if (cmd.div_load)
        begin
            dvd_reg <= {sum_reg, {rtm_pkg::RATIO_SHIFT{1'b0}}};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[P-1:0] : trial[P-1:0];
            dvd_reg <= {dvd_reg[NDD-2:0], trial_ge};
        end
        // dvd_reg holds the quotient once the divider is done
        if (cmd.update && better)
        begin
            best_dist_reg <= dvd_reg;
            best_reg      <= idx_reg;
        end
        if (cmd.finish)
        begin
            if (clamp)
            begin
                out_width_reg   <= rtm_pkg::FIELD_W'(lw_reg);
                out_height_reg  <= rtm_pkg::FIELD_W'(lh_reg);
                match_index_reg <= '0;
                outcome_reg     <= rtm_pkg::OUTCOME_CLAMPED;
            end
            else if (found_reg)
            begin
                out_width_reg   <= rtm_pkg::FIELD_W'(w1_reg);
                out_height_reg  <= rtm_pkg::FIELD_W'(h1_reg);
                match_index_reg <= best_ext[rtm_pkg::INDEX_OUT_W-1:0];
                outcome_reg     <= rtm_pkg::OUTCOME_MATCHED;
            end
            else
            begin
                out_width_reg   <= rtm_pkg::FIELD_W'(lw_reg);
                out_height_reg  <= rtm_pkg::FIELD_W'(lh_reg);
                match_index_reg <= '0;
                outcome_reg     <= rtm_pkg::OUTCOME_NO_MATCH;
            end
        end
    end

    assign best_ext    = {2'b00, best_reg};
    assign out_width   = out_width_reg;
    assign out_height  = out_height_reg;
    assign match_index = match_index_reg;
    assign outcome     = outcome_reg;

endmodule
`default_nettype wire

>>> sv/resolution_table_matcher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// resolution_table_matcher_top
// Matches a requested frame size against a table of supported sizes.
// ----------------------------------------------------------------------------
// A request is taken on a cycle with start high and busy low; busy then stays
// high until the result has been shown. The result sits on out_width,
// out_height, match_index and outcome for the single cycle in which done is
// high; it cannot be held off, so capture it on that cycle. A clamped or
// zero request goes from setup and fetch straight to finish and done. Otherwise the
// table is scanned one entry at a time: an entry that fails the size or aspect
// test passes through fetch, prep and test; one that passes also goes through
// divide, where the bit-serial divider forms its scale distance, and update.
// Write the table only while busy is low.
// ----------------------------------------------------------------------------
module resolution_table_matcher_top #(
    parameter int MAX_ENTRIES = rtm_pkg::MAX_ENTRIES_DEF,
    parameter int DIM_BITS    = rtm_pkg::DIM_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [rtm_pkg::FIELD_W-1:0]       req_width,
    input  wire logic [rtm_pkg::FIELD_W-1:0]       req_height,
    output logic                                   done,
    output logic      [rtm_pkg::FIELD_W-1:0]       out_width,
    output logic      [rtm_pkg::FIELD_W-1:0]       out_height,
    output logic      [rtm_pkg::INDEX_OUT_W-1:0]   match_index,
    output logic      [rtm_pkg::OUTCOME_W-1:0]     outcome,
    input  wire logic                              wr_en,
    input  wire logic [rtm_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  wire logic [rtm_pkg::CFG_DATA_W-1:0]    wr_data
);

    logic [rtm_pkg::COUNT_W-1:0]          count;
    logic [MAX_ENTRIES-1:0][2*DIM_BITS-1:0] entries;
    logic [rtm_pkg::PCT_W-1:0]            pct;
    rtm_pkg::dp_cmd_t                     cmd;
    rtm_pkg::dp_status_t                  status;

    rtm_regs #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DIM_BITS    (DIM_BITS)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .count    (count),
        .entries  (entries),
        .pct      (pct)
    );

    rtm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rtm_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DIM_BITS    (DIM_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .req_width   (req_width),
        .req_height  (req_height),
        .count       (count),
        .entries     (entries),
        .pct         (pct),
        .out_width   (out_width),
        .out_height  (out_height),
        .match_index (match_index),
        .outcome     (outcome)
    );

`ifndef SYNTHESIS
    // an accepted request keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // a result only appears while a request is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    // one strobe per request: the cycle after done is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("result strobe not followed by idle");

    // only a match reports an index
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (outcome != rtm_pkg::OUTCOME_MATCHED)) |-> (match_index == '0))
        else $error("index reported without a match");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the resolution table matcher against a cycle-free size matcher model.
// ----------------------------------------------------------------------------
// Requests go in on the start/busy handshake with random gaps. Every result
// strobed by done is compared with the oldest predicted result. The table, the
// entry count and the mismatch limit are reloaded only while the block is idle,
// first with a handful of directed tables, then with random tables.
// ----------------------------------------------------------------------------
module testbench;
    import rtm_pkg::*;

    localparam int ITEM_TARGET    = 1350;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 250;
    localparam int DIM_MAX        = 65535;

    // Indexes past the register list; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct {
        logic [FIELD_W-1:0]     width;
        logic [FIELD_W-1:0]     height;
        logic [INDEX_OUT_W-1:0] index;
        logic [OUTCOME_W-1:0]   outcome;
    } frame_result_t;

    class size_match_board;
        logic [COUNT_W-1:0]    entry_count;
        logic [CFG_DATA_W-1:0] size_entry [NUM_SIZE_REGS];
        logic [PCT_W-1:0]      limit_pct;
        frame_result_t         expected_q [$];
        int                    error_count;

        function new();
            entry_count = COUNT_RESET;
            for (int i = 0; i < NUM_SIZE_REGS; i++)
                size_entry[i] = SIZE_RESET[i];
            limit_pct   = PCT_RESET;
            error_count = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_ENTRY_COUNT)
                entry_count = data[COUNT_W-1:0];
            else if (idx == REG_MISMATCH_LIMIT)
                limit_pct = data[PCT_W-1:0];
            else if (idx >= REG_SIZE_ENTRY_0 && idx < REG_SIZE_ENTRY_0 + NUM_SIZE_REGS)
                size_entry[idx - REG_SIZE_ENTRY_0] = data;
        endfunction

        function int active_entries();
            if (entry_count == 0)
                return 1;
            if (entry_count > NUM_SIZE_REGS)
                return NUM_SIZE_REGS;
            return int'(entry_count);
        endfunction

        function frame_result_t match_size(logic [FIELD_W-1:0] w1, logic [FIELD_W-1:0] h1);
            frame_result_t     r;
            int                n;
            int                best;
            bit                found;
            longint unsigned   lw, lh, w0, h0, a, b, diff, mis, cand_dist, best_dist, bound;
            n     = active_entries();
            lw    = size_entry[n-1][31:WIDTH_SHIFT];
            lh    = size_entry[n-1][WIDTH_SHIFT-1:0];
            bound = (longint'(limit_pct) << RATIO_SHIFT) / PERCENT;
            found = 1'b0;
            best  = 0;
            best_dist = 0;
            r.width   = lw[FIELD_W-1:0];
            r.height  = lh[FIELD_W-1:0];
            r.index   = '0;
            if (w1 > lw || h1 > lh)
            begin
                r.outcome = OUTCOME_CLAMPED;
                return r;
            end
            if (w1 != 0 && h1 != 0)
            begin
                for (int i = 0; i < n; i++)
                begin
                    w0 = size_entry[i][31:WIDTH_SHIFT];
                    h0 = size_entry[i][WIDTH_SHIFT-1:0];
                    if (w0 >= w1 && h0 >= h1)
                    begin
                        a    = w0 * h1;
                        b    = h0 * w1;
                        diff = (a >= b) ? a - b : b - a;
                        mis  = (diff << RATIO_SHIFT) / w1 / h0;
                        if (mis <= bound)
                        begin
                            cand_dist = ((a + b) << RATIO_SHIFT) / w1 / h1;
                            if (!found || cand_dist < best_dist)
                            begin
                                found     = 1'b1;
                                best_dist = cand_dist;
                                best      = i;
                            end
                        end
                    end
                end
            end
            if (found)
            begin
                r.width   = w1;
                r.height  = h1;
                r.index   = best[INDEX_OUT_W-1:0];
                r.outcome = OUTCOME_MATCHED;
            end
            else
            begin
                r.outcome = OUTCOME_NO_MATCH;
            end
            return r;
        endfunction

        function void note_request(logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] h);
            expected_q.push_back(match_size(w, h));
        endfunction

        function void check_result(logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] h,
                                   logic [INDEX_OUT_W-1:0] idx, logic [OUTCOME_W-1:0] oc);
            frame_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result %0dx%0d index %0d outcome %0d", w, h, idx, oc);
                error_count++;
                return;
            end
            want = expected_q.pop_front();
            if (w !== want.width)
            begin
                $error("out_width: expected %0d, actual %0d", want.width, w);
                error_count++;
            end
            if (h !== want.height)
            begin
                $error("out_height: expected %0d, actual %0d", want.height, h);
                error_count++;
            end
            if (idx !== want.index)
            begin
                $error("match_index: expected %0d, actual %0d", want.index, idx);
                error_count++;
            end
            if (oc !== want.outcome)
            begin
                $error("outcome: expected %0d, actual %0d", want.outcome, oc);
                error_count++;
            end
        endfunction

        function void check_drained();
            if (expected_q.size() != 0)
            begin
                $error("%0d results never arrived", expected_q.size());
                error_count++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [FIELD_W-1:0] req_width = '0;
    logic [FIELD_W-1:0] req_height = '0;
    logic wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;

    logic busy;
    logic done;
    logic [FIELD_W-1:0] out_width;
    logic [FIELD_W-1:0] out_height;
    logic [INDEX_OUT_W-1:0] match_index;
    logic [OUTCOME_W-1:0] outcome;

    size_match_board board;
    int requests_sent = 0;
    int quiet_cycles = 0;
    bit burst_mode = 1'b0;

    resolution_table_matcher_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_width   (req_width),
        .req_height  (req_height),
        .done        (done),
        .out_width   (out_width),
        .out_height  (out_height),
        .match_index (match_index),
        .outcome     (outcome),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_result(out_width, out_height, match_index, outcome);
            if (start && !busy)
                board.note_request(req_width, req_height);
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        board.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic write_entry(input int slot, input logic [CFG_DATA_W-1:0] data);
        write_register(CFG_INDEX_W'(int'(REG_SIZE_ENTRY_0) + slot), data);
    endtask

    task automatic issue_request(input int w, input int h);
        int gap;
        int r;
        start      <= 1'b1;
        req_width  <= w[FIELD_W-1:0];
        req_height <= h[FIELD_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
        r = $urandom_range(0, 19);
        if (burst_mode || r < 10)
            gap = 0;
        else if (r < 18)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(30, 300);
        // keep start high straight into the next request when there is no gap
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_until_idle();
        start <= 1'b0;
        @(posedge clk);
        while (board.expected_q.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic load_random_table();
        int dim_w [NUM_SIZE_REGS];
        int dim_h [NUM_SIZE_REGS];
        int maxdim, aspect, tmp, r;
        logic [CFG_DATA_W-1:0] data;
        r = $urandom_range(0, 5);
        maxdim = (r == 0) ? DIM_MAX : (r == 1) ? 255 : 4095;
        aspect = $urandom_range(0, 4);
        for (int i = 0; i < NUM_SIZE_REGS; i++)
        begin
            dim_w[i] = $urandom_range(1, maxdim);
            dim_h[i] = $urandom_range(1, maxdim);
        end
        // sort ascending; heights follow an aspect or are sorted on their own
        for (int i = 0; i < NUM_SIZE_REGS - 1; i++)
            for (int j = 0; j < NUM_SIZE_REGS - 1 - i; j++)
            begin
                if (dim_w[j] > dim_w[j+1])
                begin
                    tmp = dim_w[j]; dim_w[j] = dim_w[j+1]; dim_w[j+1] = tmp;
                end
                if (dim_h[j] > dim_h[j+1])
                begin
                    tmp = dim_h[j]; dim_h[j] = dim_h[j+1]; dim_h[j+1] = tmp;
                end
            end
        for (int i = 0; i < NUM_SIZE_REGS; i++)
        begin
            case (aspect)
                0: dim_h[i] = dim_w[i] * 3 / 4;
                1: dim_h[i] = dim_w[i] * 9 / 16;
                2: dim_h[i] = dim_w[i];
                default: ;
            endcase
            if (dim_h[i] < 1)
                dim_h[i] = 1;
            data = {dim_w[i][FIELD_W-1:0], dim_h[i][FIELD_W-1:0]};
            if ($urandom_range(0, 4) == 0)
                data = $urandom;
            write_entry(i, data);
        end

        data = $urandom;
        r = $urandom_range(0, 9);
        if (r == 0)
            data[COUNT_W-1:0] = '0;
        else if (r == 1)
            data[COUNT_W-1:0] = COUNT_W'($urandom_range(NUM_SIZE_REGS + 1, 7));
        else
            data[COUNT_W-1:0] = COUNT_W'($urandom_range(1, NUM_SIZE_REGS));
        write_register(REG_ENTRY_COUNT, data);

        data = $urandom;
        r = $urandom_range(0, 4);
        if (r == 0)
            data[PCT_W-1:0] = PCT_W'(($urandom_range(0, 1) == 0) ? 0 : 127);
        else if (r == 1)
            data[PCT_W-1:0] = PCT_W'(100);
        else
            data[PCT_W-1:0] = PCT_W'($urandom_range(0, 127));
        write_register(REG_MISMATCH_LIMIT, data);

        if ($urandom_range(0, 3) == 0)
            write_register(($urandom_range(0, 1) == 0) ? REG_UNUSED_LO : REG_UNUSED_HI,
                           $urandom);
    endtask

    task automatic random_request();
        int n, pick, w, h, w0, h0, num, den, lw, lh;
        n  = board.active_entries();
        lw = board.size_entry[n-1][31:WIDTH_SHIFT];
        lh = board.size_entry[n-1][WIDTH_SHIFT-1:0];
        case ($urandom_range(0, 9))
            0:
            begin
                w = $urandom_range(0, DIM_MAX);
                h = $urandom_range(0, DIM_MAX);
            end
            1:
            begin
                w = $urandom_range(0, lw);
                h = $urandom_range(0, lh);
                if ($urandom_range(0, 1) == 0)
                    w = 0;
                else
                    h = 0;
            end
            7:
            begin
                w = $urandom_range(0, lw);
                h = $urandom_range(0, lh);
            end
            8:
            begin
                w = $urandom_range(0, lw);
                h = $urandom_range(0, lh);
                if ($urandom_range(0, 1) == 0 && lw < DIM_MAX)
                    w = lw + 1;
                else if (lh < DIM_MAX)
                    h = lh + 1;
            end
            9:
            begin
                w = $urandom_range(0, 255);
                h = $urandom_range(0, 255);
            end
            default:
            begin
                // aim at a table entry, scaled down and nudged by a few pixels
                pick = $urandom_range(0, n - 1);
                w0   = board.size_entry[pick][31:WIDTH_SHIFT];
                h0   = board.size_entry[pick][WIDTH_SHIFT-1:0];
                den  = $urandom_range(1, 4);
                num  = $urandom_range(1, den);
                w    = w0 * num / den;
                if ($urandom_range(0, 2) == 0)
                    num = $urandom_range(1, den);
                h = h0 * num / den;
                if ($urandom_range(0, 1) == 0)
                begin
                    w = w + int'($urandom_range(0, 4)) - 2;
                    h = h + int'($urandom_range(0, 4)) - 2;
                end
                if (w < 0) w = 0;
                if (h < 0) h = 0;
                if (w > DIM_MAX) w = DIM_MAX;
                if (h > DIM_MAX) h = DIM_MAX;
            end
        endcase
        issue_request(w, h);
    endtask

    initial
    begin
        int batch;
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset table: zero sizes, exact entries, clamp edges, off-aspect requests
        issue_request(0, 0);
        issue_request(0, 480);
        issue_request(640, 0);
        issue_request(DIM_MAX, DIM_MAX);
        issue_request(0, 1081);
        issue_request(1920, 1080);
        issue_request(1921, 1080);
        issue_request(1920, 1081);
        issue_request(640, 480);
        issue_request(720, 480);
        issue_request(1280, 720);
        issue_request(320, 240);
        issue_request(1, 1);
        issue_request(700, 400);
        issue_request(1920, 1);
        wait_until_idle();

        // zero entry count acts as a single entry
        write_register(REG_ENTRY_COUNT, '0);
        write_entry(0, 32'h0100_00C0);
        issue_request(256, 192);
        issue_request(128, 96);
        issue_request(257, 192);
        wait_until_idle();

        // oversized count, full-scale entries, zero limit, writes past the list
        write_register(REG_ENTRY_COUNT, 32'hFFFF_FFF7);
        write_entry(0, 32'h0000_0000);
        write_entry(1, 32'h0010_0010);
        write_entry(2, 32'h8000_8000);
        write_entry(3, 32'hFFFF_FFFF);
        write_register(REG_MISMATCH_LIMIT, 32'hFFFF_FF80);
        write_register(REG_UNUSED_LO, 32'hFFFF_FFFF);
        write_register(REG_UNUSED_HI, 32'h0000_0001);
        issue_request(DIM_MAX, DIM_MAX);
        issue_request(16, 16);
        issue_request(1, 1);
        issue_request(2, 1);
        wait_until_idle();

        // unsorted table with the loosest limit
        write_entry(0, 32'h0780_0438);
        write_entry(1, 32'h0500_02D0);
        write_entry(2, 32'h0280_01E0);
        write_entry(3, 32'h0100_0100);
        write_register(REG_MISMATCH_LIMIT, 32'h0000_007F);
        issue_request(300, 200);
        issue_request(200, 100);
        issue_request(256, 256);
        wait_until_idle();

        while (requests_sent < ITEM_TARGET)
        begin
            load_random_table();
            burst_mode = ($urandom_range(0, 4) == 0);
            batch = $urandom_range(10, 60);
            repeat (batch) random_request();
            wait_until_idle();
        end
        burst_mode = 1'b0;

        wait_until_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        board.check_drained();
        if (board.error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
